[src/lcf_pkg.sv]
// Shared types and constants for the label collision filter.
package lcf_pkg;

    // Command carried in the input tuser field.
    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Box geometry: each character is 16 pixels wide and every box has a fixed margin.
    localparam int PIX_PER_CHAR_LOG2 = 4;
    localparam int BOX_EXTRA         = 56;

    // Width of the reported kept count.
    localparam int KEPT_W = 9;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

[src/lcf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/lcf_overlap_unit.sv]
// Shared compare unit: inclusive overlap test of the new box against one kept box.
module lcf_overlap_unit #(
    parameter int LW = 32,
    parameter int RW = 33
) (
    input  logic [LW-1:0] new_left,
    input  logic [LW-1:0] new_top,
    input  logic [RW-1:0] new_right,
    input  logic [RW-1:0] new_bottom,
    input  logic [LW-1:0] kept_left,
    input  logic [LW-1:0] kept_top,
    input  logic [RW-1:0] kept_right,
    input  logic [RW-1:0] kept_bottom,
    output logic          hit
);

    logic x_hit;
    logic y_hit;

    // Both boxes are well formed (left <= right, top <= bottom), so the
    // min/max test reduces to two cross compares per axis. Touching edges overlap.
    assign x_hit = (kept_right >= RW'(new_left)) && (new_right >= RW'(kept_left));
    assign y_hit = (kept_bottom >= RW'(new_top)) && (new_bottom >= RW'(kept_top));
    assign hit   = x_hit && y_hit;

endmodule

[src/label_collision_filter.sv]
// Top level of the greedy label collision filter.
//
// Each input transfer either places a label (tuser = 0) or clears all kept
// boxes (tuser = 1). A placed label gets the box left = x, top = y,
// right = x + 16*len + 56, bottom = y + 56, and is tested with inclusive
// edges against every kept box; it is stored and accepted only if nothing
// overlaps and the store has room. Every input transfer yields exactly one
// result transfer with the accepted flag, the store-full flag and the kept
// count. Kept boxes live in one RAM with a single read port, read one box
// per cycle by a small sequencer feeding one shared compare unit, so a
// place transfer occupies the block while the kept boxes are scanned (the
// scan stops early at the first overlap) and a clear transfer skips the scan.
// The input is not ready while an item is in work; a finished result waits
// in the output register and the block goes back to ready as soon as it has
// been loaded there. No clearing pass is needed after reset.
module label_collision_filter #(
    parameter int CAPACITY   = 256,
    parameter int COORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata fields from bit 0: pos_x[31:0], pos_y[63:32], name_len[71:64].
    input  logic [71:0] s_tdata,
    // s_tuser fields from bit 0: cmd[0].
    input  logic [0:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata fields from bit 0: accepted[0], store_full[1], kept_count[10:2].
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    // Stored coordinate widths: left/top keep the masked input, right/bottom
    // are wide enough to hold the largest box extent without wrap.
    localparam int LW    = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int RW    = ((LW > 13) ? LW : 13) + 1;
    localparam int MEM_W = 2 * LW + 2 * RW;
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    lcf_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;
    logic             issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;
    logic             hit_reg, hit_next;
    logic             clear_reg, clear_next;
    logic             m_valid_reg, m_valid_next;

    logic [LW-1:0]    left_reg, left_next;
    logic [LW-1:0]    top_reg, top_next;
    logic [RW-1:0]    right_reg, right_next;
    logic [RW-1:0]    bottom_reg, bottom_next;
    logic             acc_reg, acc_next;
    logic             full_reg, full_next;
    logic [lcf_pkg::KEPT_W-1:0] kept_reg, kept_next;

    logic             in_fire;
    logic             last_issue;
    logic             out_free;
    logic             store_is_full;
    logic             ram_we;
    logic             ram_re;
    logic [MEM_W-1:0] ram_wdata;
    logic [MEM_W-1:0] ram_rdata;
    logic             box_hit;

    logic [LW-1:0]    in_left;
    logic [LW-1:0]    in_top;
    logic [7:0]       in_len;

    assign in_fire       = s_tvalid && s_tready;
    assign s_tready      = (state_reg == lcf_pkg::ST_IDLE);
    assign out_free      = !m_valid_reg || m_tready;
    assign store_is_full = (count_reg == CNT_W'(CAPACITY));
    assign last_issue    = (CNT_W'(rd_idx_reg) == count_reg - CNT_W'(1));

    // Unpack the input transfer; coordinates are taken modulo the coordinate width.
    assign in_left = LW'(s_tdata[31:0]);
    assign in_top  = LW'(s_tdata[63:32]);
    assign in_len  = s_tdata[71:64];

    // Box memory: one read per scan cycle, one write when a label is kept.
    assign ram_re    = (state_reg == lcf_pkg::ST_SCAN) && issue_reg;
    assign ram_we    = (state_reg == lcf_pkg::ST_DONE) && out_free && !clear_reg
                       && !hit_reg && !store_is_full;
    assign ram_wdata = {bottom_reg, right_reg, top_reg, left_reg};

    lcf_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CAPACITY)
    ) u_box_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    lcf_overlap_unit #(
        .LW (LW),
        .RW (RW)
    ) u_overlap (
        .new_left    (left_reg),
        .new_top     (top_reg),
        .new_right   (right_reg),
        .new_bottom  (bottom_reg),
        .kept_left   (ram_rdata[LW-1:0]),
        .kept_top    (ram_rdata[2*LW-1:LW]),
        .kept_right  (ram_rdata[2*LW+RW-1:2*LW]),
        .kept_bottom (ram_rdata[MEM_W-1:2*LW+RW]),
        .hit         (box_hit)
    );

    // Sequencer: accept, scan the kept boxes (skipped for a clear or an empty store), then decide and post the result.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        hit_next       = hit_reg;
        clear_next     = clear_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        left_next      = left_reg;
        top_next       = top_reg;
        right_next     = right_reg;
        bottom_next    = bottom_reg;
        acc_next       = acc_reg;
        full_next      = full_reg;
        kept_next      = kept_reg;

        unique case (state_reg)
            lcf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    left_next   = in_left;
                    top_next    = in_top;
                    right_next  = RW'(in_left) + (RW'(in_len) << lcf_pkg::PIX_PER_CHAR_LOG2)
                                  + RW'(lcf_pkg::BOX_EXTRA);
                    bottom_next = RW'(in_top) + RW'(lcf_pkg::BOX_EXTRA);
                    clear_next  = (s_tuser[0] == lcf_pkg::CMD_CLEAR);
                    hit_next    = 1'b0;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    pend_last_next = 1'b0;
                    if (s_tuser[0] == lcf_pkg::CMD_CLEAR || count_reg == '0) begin
                        issue_next = 1'b0;
                        state_next = lcf_pkg::ST_DONE;
                    end else begin
                        issue_next = 1'b1;
                        state_next = lcf_pkg::ST_SCAN;
                    end
                end
            end
            lcf_pkg::ST_SCAN: begin
                // Issue side: step the read address up to the last kept box.
                pend_next      = issue_reg;
                pend_last_next = issue_reg && last_issue;
                if (issue_reg) begin
                    issue_next = !last_issue;
                    if (!last_issue) begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                    end
                end
                // Compare side: the box read last cycle is checked now.
                if (pend_reg && box_hit) begin
                    hit_next   = 1'b1;
                    issue_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = lcf_pkg::ST_DONE;
                end else if (pend_reg && pend_last_reg) begin
                    issue_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = lcf_pkg::ST_DONE;
                end
            end
            lcf_pkg::ST_DONE: begin
                if (out_free) begin
                    acc_next  = 1'b0;
                    full_next = 1'b0;
                    if (clear_reg) begin
                        count_next = '0;
                    end else if (!hit_reg) begin
                        if (store_is_full) begin
                            full_next = 1'b1;
                        end else begin
                            acc_next   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    kept_next    = lcf_pkg::KEPT_W'(count_next);
                    m_valid_next = 1'b1;
                    state_next   = lcf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lcf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lcf_pkg::ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        hit_reg    <= hit_next;
        clear_reg  <= clear_next;
        left_reg   <= left_next;
        top_reg    <= top_next;
        right_reg  <= right_next;
        bottom_reg <= bottom_next;
        acc_reg    <= acc_next;
        full_reg   <= full_next;
        kept_reg   <= kept_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, kept_reg, full_reg, acc_reg};

    // The kept count never exceeds the store size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("kept count exceeds capacity");

    // Only boxes that have been written are ever read.
    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> (CNT_W'(rd_idx_reg) < count_reg))
        else $error("box read beyond kept count");

    // A scan is only started with at least one kept box.
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lcf_pkg::ST_SCAN) |-> (count_reg != '0))
        else $error("scan with empty store");

    // Storing a box raises the count by one at the next edge.
    a_write_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("box write without count update");

endmodule
